// ===== hdl/rac_pkg.sv =====
// ----------------------------------------------------------------------------
// rac_pkg
// Shared widths, constants and the record that travels along the cell chain
// of the radial alpha circle pixel block.
// ----------------------------------------------------------------------------
package rac_pkg;

    localparam int RAC_MAX_RADIUS = 256;

    // Field widths
    localparam int COORD_W = 9;
    localparam int RADIUS_W = 9;
    localparam int INDEX_W = 18;
    localparam int ALPHA_W = 8;

    // Internal widths, sized for the largest radius the register can hold
    localparam int DIAM_W = RADIUS_W + 1;
    localparam int SQ_W = 2 * RADIUS_W;        // one coordinate or radius squared
    localparam int D2_W = SQ_W + 1;            // dx*dx + dy*dy
    localparam int PROD_W = COORD_W + DIAM_W;  // row times diameter
    localparam int K_W = ALPHA_W;              // bits of the alpha search
    localparam int KRR_W = K_W + SQ_W;         // k * r * r
    localparam int ACC_W = 36;                 // target and running square

    localparam int ALPHA_FULL = 255;
    localparam int ALPHA_SQ = ALPHA_FULL * ALPHA_FULL;
    localparam int ALPHA_SQ_W = 16;

    typedef struct packed {
        logic                valid;
        logic                err;
        logic                in_circle;
        logic [INDEX_W-1:0]  index;
        logic [SQ_W-1:0]     rr;
        logic [ACC_W-1:0]    target;
        logic [K_W-1:0]      k;
        logic [KRR_W-1:0]    krr;
        logic [ACC_W-1:0]    sq;
    } t_cell_data;

endpackage

// ===== hdl/radial_alpha_circle_pixel.sv =====
// ----------------------------------------------------------------------------
// radial_alpha_circle_pixel
// Filled circle pixel with radial alpha: index, inside flag, alpha and
// coordinate error for one pixel of a square of side twice the radius.
//
// Usage:
//   Raise start with i_pos_x / i_pos_y for one cycle per pixel request.
//   busy is always low, so a request may be presented every cycle.
//   Each result appears for exactly one cycle, marked by o_done, after
//   4 front stages, 8 search cells (one alpha bit each) and the output
//   register. Throughput is one pixel per clock.
//   The radius is written through i_cfg_we / i_cfg_data and should only
//   change while no request is in flight; values above MAX_RADIUS saturate.
//   Synchronous reset clears all in-flight requests and sets the radius
//   to 16. The receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
module radial_alpha_circle_pixel #(
    parameter int MAX_RADIUS = rac_pkg::RAC_MAX_RADIUS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [rac_pkg::COORD_W-1:0]    i_pos_x,
    input  logic [rac_pkg::COORD_W-1:0]    i_pos_y,
    input  logic                           i_cfg_we,
    input  logic [rac_pkg::RADIUS_W-1:0]   i_cfg_data,
    output logic                           o_done,
    output logic [rac_pkg::INDEX_W-1:0]    o_pixel_index,
    output logic                           o_inside_res,
    output logic [rac_pkg::ALPHA_W-1:0]    o_alpha,
    output logic                           o_coord_error
);
    import rac_pkg::*;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(16);

    logic [RADIUS_W-1:0] r_radius;
    t_cell_data          chain [0:K_W];
    logic [K_W-1:0]      k_final;

    logic                r_done;
    logic [INDEX_W-1:0]  r_index;
    logic                r_inside;
    logic [ALPHA_W-1:0]  r_alpha;
    logic                r_err;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
        end else if (i_cfg_we) begin
            r_radius <= i_cfg_data;
        end
    end

    rac_front #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (start),
        .i_pos_x  (i_pos_x),
        .i_pos_y  (i_pos_y),
        .i_radius (r_radius),
        .o_data   (chain[0])
    );

    // most significant alpha bit first
    for (genvar g = 0; g < K_W; g++) begin : g_cell
        rac_cell #(
            .BIT_POS (K_W - 1 - g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_data  (chain[g]),
            .o_data  (chain[g+1])
        );
    end

    // the search finds the largest k below the target; the answer is one above
    assign k_final = (chain[K_W].target == '0) ? '0 : chain[K_W].k + K_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= chain[K_W].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_err    <= chain[K_W].err;
        r_index  <= chain[K_W].err ? '0 : chain[K_W].index;
        r_inside <= !chain[K_W].err && chain[K_W].in_circle;
        r_alpha  <= (!chain[K_W].err && chain[K_W].in_circle)
                  ? ALPHA_W'(ALPHA_FULL) - k_final : '0;
    end

    assign o_done        = r_done;
    assign o_pixel_index = r_index;
    assign o_inside_res  = r_inside;
    assign o_alpha       = r_alpha;
    assign o_coord_error = r_err;

endmodule

// ===== hdl/rac_front.sv =====
// ----------------------------------------------------------------------------
// rac_front
// Four-stage front end: range check and offsets, squares and row product,
// distance and inside test, then the scaled target for the alpha search.
// ----------------------------------------------------------------------------
module rac_front #(
    parameter int MAX_RADIUS = rac_pkg::RAC_MAX_RADIUS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_req,
    input  logic [rac_pkg::COORD_W-1:0]    i_pos_x,
    input  logic [rac_pkg::COORD_W-1:0]    i_pos_y,
    input  logic [rac_pkg::RADIUS_W-1:0]   i_radius,
    output rac_pkg::t_cell_data            o_data
);
    import rac_pkg::*;

    localparam int CMP_W = 13;

    logic [RADIUS_W-1:0] radius_sat;
    logic [DIAM_W-1:0]   diam;

    // stage A
    logic                r_a_valid, r_a_err;
    logic [COORD_W-1:0]  r_a_x, r_a_y, r_a_ax, r_a_ay;
    logic [RADIUS_W-1:0] r_a_r;
    logic [DIAM_W-1:0]   r_a_diam;
    // stage B
    logic                r_b_valid, r_b_err;
    logic [COORD_W-1:0]  r_b_x;
    logic [SQ_W-1:0]     r_b_ax2, r_b_ay2, r_b_rr;
    logic [PROD_W-1:0]   r_b_ydiam;
    // stage C
    logic                r_c_valid, r_c_err, r_c_inside;
    logic [INDEX_W-1:0]  r_c_index;
    logic [SQ_W-1:0]     r_c_rr;
    logic [D2_W-1:0]     r_c_d2;
    logic [D2_W-1:0]     d2;
    logic [PROD_W:0]     index_full;
    // stage D
    t_cell_data          r_d;

    assign radius_sat = ({{(CMP_W-RADIUS_W){1'b0}}, i_radius} > CMP_W'(MAX_RADIUS))
                      ? RADIUS_W'(MAX_RADIUS) : i_radius;
    assign diam = {radius_sat, 1'b0};

    assign d2 = D2_W'(r_b_ax2) + D2_W'(r_b_ay2);
    assign index_full = (PROD_W+1)'(r_b_ydiam) + (PROD_W+1)'(r_b_x);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d.valid <= 1'b0;
        end else begin
            r_a_valid <= i_req;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d.valid <= r_c_valid;
        end
        // stage A: offsets from centre and square bounds
        r_a_x    <= i_pos_x;
        r_a_y    <= i_pos_y;
        r_a_r    <= radius_sat;
        r_a_diam <= diam;
        r_a_err  <= ({1'b0, i_pos_x} >= diam) || ({1'b0, i_pos_y} >= diam);
        r_a_ax   <= (i_pos_x >= radius_sat) ? i_pos_x - radius_sat : radius_sat - i_pos_x;
        r_a_ay   <= (i_pos_y >= radius_sat) ? i_pos_y - radius_sat : radius_sat - i_pos_y;
        // stage B: products
        r_b_err   <= r_a_err;
        r_b_x     <= r_a_x;
        r_b_ax2   <= SQ_W'(r_a_ax) * SQ_W'(r_a_ax);
        r_b_ay2   <= SQ_W'(r_a_ay) * SQ_W'(r_a_ay);
        r_b_rr    <= SQ_W'(r_a_r) * SQ_W'(r_a_r);
        r_b_ydiam <= PROD_W'(r_a_y) * PROD_W'(r_a_diam);
        // stage C: distance and inside test
        r_c_err    <= r_b_err;
        r_c_d2     <= d2;
        r_c_rr     <= r_b_rr;
        r_c_inside <= d2 < D2_W'(r_b_rr);
        r_c_index  <= index_full[INDEX_W-1:0];
        // stage D: scaled target, search starts from zero
        r_d.err       <= r_c_err;
        r_d.in_circle <= r_c_inside;
        r_d.index     <= r_c_index;
        r_d.rr        <= r_c_rr;
        r_d.target    <= ACC_W'(r_c_d2) * ACC_W'(ALPHA_SQ);
        r_d.k         <= '0;
        r_d.krr       <= '0;
        r_d.sq        <= '0;
    end

    assign o_data = r_d;

endmodule

// ===== hdl/rac_cell.sv =====
// ----------------------------------------------------------------------------
// rac_cell
// One bit of the alpha search: tries k with this bit set and keeps it when
// (k*r)^2 stays below the target. Squares are updated by shifts and adds.
// ----------------------------------------------------------------------------
module rac_cell #(
    parameter int BIT_POS = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rac_pkg::t_cell_data i_data,
    output rac_pkg::t_cell_data o_data
);
    import rac_pkg::*;

    t_cell_data       r_data;
    t_cell_data       n_data;
    logic [ACC_W-1:0] sq_cand;

    // (k + 2^b)^2 rr = k^2 rr + 2^(b+1) k rr + 2^(2b) rr
    assign sq_cand = i_data.sq
                   + (ACC_W'(i_data.krr) << (BIT_POS + 1))
                   + (ACC_W'(i_data.rr) << (2 * BIT_POS));

    always_comb begin
        n_data = i_data;
        if (sq_cand < i_data.target) begin
            n_data.k[BIT_POS] = 1'b1;
            n_data.krr        = i_data.krr + (KRR_W'(i_data.rr) << BIT_POS);
            n_data.sq         = sq_cand;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data.valid <= 1'b0;
        end else begin
            r_data.valid <= i_data.valid;
        end
        r_data.err       <= n_data.err;
        r_data.in_circle <= n_data.in_circle;
        r_data.index     <= n_data.index;
        r_data.rr        <= n_data.rr;
        r_data.target    <= n_data.target;
        r_data.k         <= n_data.k;
        r_data.krr       <= n_data.krr;
        r_data.sq        <= n_data.sq;
    end

    assign o_data = r_data;

endmodule
